// ===== rtl/aspt_pkg.sv =====
// Package for the allocation site profile table.
// Holds op and status codes, the slot entry type and the control/status structs.
// No dependencies.
package aspt_pkg;

  localparam logic [2:0] OP_ALLOC = 3'd0;
  localparam logic [2:0] OP_SURV  = 3'd1;
  localparam logic [2:0] OP_PROM  = 3'd2;
  localparam logic [2:0] OP_DECAY = 3'd3;
  localparam logic [2:0] OP_SCAN  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NO_CAND   = 2'd3;

  // Source of the fields of an emitted word.
  localparam logic [1:0] EM_UPD   = 2'd0;
  localparam logic [1:0] EM_PEND  = 2'd1;
  localparam logic [1:0] EM_KEY   = 2'd2;
  localparam logic [1:0] EM_BLANK = 2'd3;

  localparam logic REG_THRESHOLD   = 1'b0;
  localparam logic REG_MIN_SAMPLES = 1'b1;

  localparam int unsigned OUT_LIMIT  = 64;
  localparam int unsigned SIZE_SHIFT = 3;

  typedef struct packed {
    logic [31:0] site;
    logic [31:0] allocs;
    logic [47:0] bytes;
    logic [31:0] surv;
    logic [31:0] prom;
    logic [7:0]  tag;
    logic [15:0] cls;
  } entry_t;

  typedef struct packed {
    logic       load;
    logic       rd;
    logic       claim;
    logic       upd;
    logic       dec;
    logic       mul;
    logic       pend_ld;
    logic       emit;
    logic [1:0] emit_sel;
    logic [1:0] status;
    logic       last;
    logic [2:0] op;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic qual;
    logic last_slot;
    logic empty;
    logic full;
  } stat_t;

endpackage

// ===== rtl/aspt_dp.sv =====
// Datapath of the allocation site profile table: slot memory, counters,
// configuration registers and result registers. Depends on aspt_pkg.
module aspt_dp #(
  parameter int unsigned SITES = 64,
  parameter int unsigned IW    = $clog2(SITES),
  parameter int unsigned UW    = $clog2(SITES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  aspt_pkg::cmd_t      cmd_i,
  input  logic [IW-1:0]       idx_i,
  input  logic [IW-1:0]       rd_addr_i,
  output aspt_pkg::stat_t     stat_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic [31:0]         site_id_i,
  input  logic [31:0]         alloc_bytes_i,
  input  logic [7:0]          type_tag_i,
  output logic                result_valid_o,
  output logic [1:0]          status_o,
  output logic [31:0]         out_site_o,
  output logic [31:0]         site_allocs_o,
  output logic [47:0]         site_bytes_o,
  output logic [31:0]         site_survivals_o,
  output logic [31:0]         site_promotions_o,
  output logic [7:0]          last_tag_o,
  output logic [15:0]         last_class_o,
  output logic [63:0]         bytes_all_sites_o,
  output logic [6:0]          sites_in_use_o,
  output logic                last_o
);

  aspt_pkg::entry_t mem_q [SITES];
  aspt_pkg::entry_t rd_q, pend_q, base, upd_e, dec_e, em_e;
  logic [8:0]  thr_q;
  logic [31:0] min_q;
  logic [31:0] key_q, bytes_q;
  logic [7:0]  tag_q;
  logic [UW-1:0] used_q, used_d;
  logic [63:0] grand_q, grand_d;
  logic [40:0] prod_q;
  logic [48:0] bsum;
  logic [64:0] gsum;
  logic [IW-1:0] wr_addr;
  logic [31:0] used_ext;
  logic [31:0] em_site;
  logic [1:0]  st_q;
  logic        valid_q, last_q;
  aspt_pkg::entry_t out_q;
  logic [63:0] out_grand_q;
  logic [6:0]  out_used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 9'd128;
      min_q <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        aspt_pkg::REG_THRESHOLD:   thr_q <= cfg_wdata_i[8:0];
        aspt_pkg::REG_MIN_SAMPLES: min_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q   <= site_id_i;
      bytes_q <= alloc_bytes_i;
      tag_q   <= type_tag_i;
    end
  end

  always_comb begin
    base = cmd_i.claim ? '0 : rd_q;
    upd_e = base;
    upd_e.site = key_q;
    bsum = {1'b0, base.bytes} + {17'd0, bytes_q};
    gsum = {1'b0, grand_q} + {33'd0, bytes_q};
    grand_d = grand_q;
    case (cmd_i.op)
      aspt_pkg::OP_ALLOC: begin
        upd_e.allocs = (&base.allocs) ? base.allocs : base.allocs + 32'd1;
        upd_e.bytes  = bsum[48] ? {48{1'b1}} : bsum[47:0];
        upd_e.tag    = tag_q;
        upd_e.cls    = bytes_q[aspt_pkg::SIZE_SHIFT +: 16];
        grand_d      = gsum[64] ? {64{1'b1}} : gsum[63:0];
      end
      aspt_pkg::OP_SURV:
        upd_e.surv = (&base.surv) ? base.surv : base.surv + 32'd1;
      aspt_pkg::OP_PROM:
        upd_e.prom = (&base.prom) ? base.prom : base.prom + 32'd1;
      default: ;
    endcase
    dec_e = rd_q;
    dec_e.allocs = rd_q.allocs >> 1;
    dec_e.bytes  = rd_q.bytes >> 1;
    dec_e.surv   = rd_q.surv >> 1;
    dec_e.prom   = rd_q.prom >> 1;
    wr_addr = cmd_i.claim ? used_q[IW-1:0] : idx_i;
    used_d = (cmd_i.upd && cmd_i.claim) ? used_q + UW'(1) : used_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      mem_q[wr_addr] <= upd_e;
    end else if (cmd_i.dec) begin
      mem_q[idx_i] <= dec_e;
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[rd_addr_i];
    end
    if (cmd_i.mul) begin
      prod_q <= thr_q * rd_q.allocs;
    end
    if (cmd_i.pend_ld) begin
      pend_q <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      grand_q <= '0;
    end else if (cmd_i.upd) begin
      used_q  <= used_d;
      grand_q <= grand_d;
    end
  end

  always_comb begin
    stat_o.empty     = (used_q == '0);
    stat_o.full      = (used_q == UW'(SITES));
    stat_o.last_slot = (UW'(idx_i) + UW'(1) == used_q);
    stat_o.match     = !stat_o.empty && (rd_q.site == key_q);
    // A site with zero count qualifies only under a zero threshold.
    stat_o.qual = !stat_o.empty && (rd_q.allocs >= min_q) &&
                  ((rd_q.allocs == '0) ? (thr_q == '0)
                                       : ({1'b0, rd_q.surv, 8'd0} >= prod_q));
  end

  always_comb begin
    em_e = '0;
    em_site = '0;
    case (cmd_i.emit_sel)
      aspt_pkg::EM_UPD: begin
        em_e = upd_e;
        em_site = key_q;
      end
      aspt_pkg::EM_PEND: begin
        em_e = pend_q;
        em_site = pend_q.site;
      end
      aspt_pkg::EM_KEY: em_site = key_q;
      default: ;
    endcase
    em_e.site = em_site;
    used_ext = 32'(used_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q       <= em_e;
      st_q        <= cmd_i.status;
      last_q      <= cmd_i.last;
      out_grand_q <= cmd_i.upd ? grand_d : grand_q;
      out_used_q  <= used_ext[6:0];
    end
  end

  assign result_valid_o    = valid_q;
  assign status_o          = st_q;
  assign out_site_o        = out_q.site;
  assign site_allocs_o     = out_q.allocs;
  assign site_bytes_o      = out_q.bytes;
  assign site_survivals_o  = out_q.surv;
  assign site_promotions_o = out_q.prom;
  assign last_tag_o        = out_q.tag;
  assign last_class_o      = out_q.cls;
  assign bytes_all_sites_o = out_grand_q;
  assign sites_in_use_o    = out_used_q;
  assign last_o            = last_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(SITES)) else $error("slot fill count beyond capacity");
  a_no_claim_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd && cmd_i.claim |-> !stat_o.full) else $error("claim on full table");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.upd && cmd_i.dec)) else $error("two slot writes at once");

endmodule

// ===== rtl/aspt_ctrl.sv =====
// Controller of the allocation site profile table: sequences slot search,
// update, decay walk and candidate scan. Depends on aspt_pkg.
module aspt_ctrl #(
  parameter int unsigned SITES = 64,
  parameter int unsigned IW    = $clog2(SITES)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [2:0]      op_i,
  input  aspt_pkg::stat_t stat_i,
  output aspt_pkg::cmd_t  cmd_o,
  output logic [IW-1:0]   idx_o,
  output logic [IW-1:0]   rd_addr_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SRCH_RD  = 4'd1;
  localparam logic [3:0] S_SRCH_CMP = 4'd2;
  localparam logic [3:0] S_UPD      = 4'd3;
  localparam logic [3:0] S_DEC_RD   = 4'd4;
  localparam logic [3:0] S_DEC_WR   = 4'd5;
  localparam logic [3:0] S_SCAN_RD  = 4'd6;
  localparam logic [3:0] S_SCAN_MUL = 4'd7;
  localparam logic [3:0] S_SCAN_DEC = 4'd8;
  localparam logic [3:0] S_FLUSH    = 4'd9;

  logic [3:0]    state_q, state_d;
  logic [2:0]    op_q, op_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [6:0]    cnt_q, cnt_d;
  logic          claim_q, claim_d;
  logic          last_walk;

  assign busy      = (state_q != S_IDLE);
  assign idx_o     = idx_q;
  assign last_walk = stat_i.last_slot || stat_i.empty;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    claim_d = claim_q;
    cmd_o   = '0;
    cmd_o.op = op_q;
    rd_addr_o = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          op_d  = op_i;
          idx_d = '0;
          cnt_d = '0;
          unique case (op_i) inside
            aspt_pkg::OP_ALLOC, aspt_pkg::OP_SURV,
            aspt_pkg::OP_PROM:  state_d = S_SRCH_RD;
            aspt_pkg::OP_DECAY: state_d = S_DEC_RD;
            aspt_pkg::OP_SCAN:  state_d = S_SCAN_RD;
            default: ;
          endcase
        end
      end
      S_SRCH_RD: begin
        cmd_o.rd = 1'b1;
        state_d = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (stat_i.match) begin
          claim_d = 1'b0;
          state_d = S_UPD;
        end else if (last_walk) begin
          if (op_q == aspt_pkg::OP_ALLOC && !stat_i.full) begin
            claim_d = 1'b1;
            state_d = S_UPD;
          end else begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = aspt_pkg::EM_KEY;
            cmd_o.status   = (op_q == aspt_pkg::OP_ALLOC) ? aspt_pkg::ST_FULL
                                                          : aspt_pkg::ST_NOT_FOUND;
            cmd_o.last     = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          idx_d = idx_q + IW'(1);
          rd_addr_o = idx_d;
          cmd_o.rd = 1'b1;
        end
      end
      S_UPD: begin
        cmd_o.upd      = 1'b1;
        cmd_o.claim    = claim_q;
        cmd_o.emit     = 1'b1;
        cmd_o.emit_sel = aspt_pkg::EM_UPD;
        cmd_o.status   = aspt_pkg::ST_OK;
        cmd_o.last     = 1'b1;
        state_d = S_IDLE;
      end
      S_DEC_RD: begin
        cmd_o.rd = 1'b1;
        state_d = S_DEC_WR;
      end
      S_DEC_WR: begin
        cmd_o.dec = !stat_i.empty;
        if (last_walk) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = aspt_pkg::EM_BLANK;
          cmd_o.status   = aspt_pkg::ST_OK;
          cmd_o.last     = 1'b1;
          state_d = S_IDLE;
        end else begin
          // Read the next slot while the halved one is written back.
          idx_d = idx_q + IW'(1);
          rd_addr_o = idx_d;
          cmd_o.rd = 1'b1;
        end
      end
      S_SCAN_RD: begin
        cmd_o.rd = 1'b1;
        state_d = S_SCAN_MUL;
      end
      S_SCAN_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_SCAN_DEC;
      end
      S_SCAN_DEC: begin
        // A qualifier is held back one step so that the final word can carry last.
        if (stat_i.qual) begin
          cmd_o.pend_ld = 1'b1;
          if (cnt_q != '0) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = aspt_pkg::EM_PEND;
            cmd_o.status   = aspt_pkg::ST_OK;
          end
          cnt_d = cnt_q + 7'd1;
        end
        if (stat_i.qual && cnt_q == 7'(aspt_pkg::OUT_LIMIT - 1)) begin
          state_d = S_FLUSH;
        end else if (last_walk) begin
          state_d = S_FLUSH;
        end else begin
          idx_d = idx_q + IW'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_FLUSH: begin
        cmd_o.emit   = 1'b1;
        cmd_o.last   = 1'b1;
        if (cnt_q != '0) begin
          cmd_o.emit_sel = aspt_pkg::EM_PEND;
          cmd_o.status   = aspt_pkg::ST_OK;
        end else begin
          cmd_o.emit_sel = aspt_pkg::EM_BLANK;
          cmd_o.status   = aspt_pkg::ST_NO_CAND;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= aspt_pkg::OP_ALLOC;
      idx_q   <= '0;
      cnt_q   <= '0;
      claim_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      claim_q <= claim_d;
    end
  end

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && cmd_o.last |=> state_q == S_IDLE) else $error("last word without end");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 7'(aspt_pkg::OUT_LIMIT)) else $error("scan count beyond limit");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !cmd_o.emit && !cmd_o.upd && !cmd_o.dec)
    else $error("datapath action while idle");

endmodule

// ===== rtl/allocation_site_profile_table.sv =====
// Allocation site profile table: SITES slots searched one slot per cycle through a
// single-read-port slot memory; an empty table still has one slot walked. The final word
// is registered; busy is low while that word is out, so the next item can be taken at
// the edge ending it.
// Reset empties the table through its fill count; the receiver cannot stall.
module allocation_site_profile_table #(
  parameter int unsigned SITES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op_i,
  input  logic [31:0] site_id_i,
  input  logic [31:0] alloc_bytes_i,
  input  logic [7:0]  type_tag_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [31:0] out_site_o,
  output logic [31:0] site_allocs_o,
  output logic [47:0] site_bytes_o,
  output logic [31:0] site_survivals_o,
  output logic [31:0] site_promotions_o,
  output logic [7:0]  last_tag_o,
  output logic [15:0] last_class_o,
  output logic [63:0] bytes_all_sites_o,
  output logic [6:0]  sites_in_use_o,
  output logic        last_o
);

  localparam int unsigned IW = $clog2(SITES);

  aspt_pkg::cmd_t  cmd;
  aspt_pkg::stat_t stat;
  logic [IW-1:0]   idx, rd_addr;

  aspt_ctrl #(.SITES(SITES)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .op_i      (op_i),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .idx_o     (idx),
    .rd_addr_o (rd_addr)
  );

  aspt_dp #(.SITES(SITES)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .idx_i             (idx),
    .rd_addr_i         (rd_addr),
    .stat_o            (stat),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .site_id_i         (site_id_i),
    .alloc_bytes_i     (alloc_bytes_i),
    .type_tag_i        (type_tag_i),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .out_site_o        (out_site_o),
    .site_allocs_o     (site_allocs_o),
    .site_bytes_o      (site_bytes_o),
    .site_survivals_o  (site_survivals_o),
    .site_promotions_o (site_promotions_o),
    .last_tag_o        (last_tag_o),
    .last_class_o      (last_class_o),
    .bytes_all_sites_o (bytes_all_sites_o),
    .sites_in_use_o    (sites_in_use_o),
    .last_o            (last_o)
  );

endmodule

// ===== dv/aspt_checker.sv =====
// Checker for the allocation site profile table: watches the command, config and
// result ports, predicts every result word and compares it with the whole word seen.
// Depends on aspt_pkg for op, status and register codes.
`timescale 1ns / 100ps
module aspt_checker #(
  parameter int unsigned SITES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [2:0]  op_i,
  input  logic [31:0] site_id_i,
  input  logic [31:0] alloc_bytes_i,
  input  logic [7:0]  type_tag_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        result_valid_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] out_site_i,
  input  logic [31:0] site_allocs_i,
  input  logic [47:0] site_bytes_i,
  input  logic [31:0] site_survivals_i,
  input  logic [31:0] site_promotions_i,
  input  logic [7:0]  last_tag_i,
  input  logic [15:0] last_class_i,
  input  logic [63:0] bytes_all_sites_i,
  input  logic [6:0]  sites_in_use_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          words_pending_o,
  output int          words_checked_o,
  output int          full_drops_o,
  output int          scan_words_o
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] site;
    logic [31:0] allocs;
    logic [47:0] bytes;
    logic [31:0] surv;
    logic [31:0] prom;
    logic [7:0]  tag;
    logic [15:0] cls;
    logic [63:0] grand;
    logic [6:0]  used;
    logic        last;
  } profile_word_t;

  localparam logic [47:0] BYTES_MAX = '1;
  localparam logic [31:0] COUNT_MAX = '1;
  localparam logic [63:0] GRAND_MAX = '1;

  profile_word_t expected_words[$];

  logic [8:0]        thr_q8;
  logic [31:0]       min_samples;
  logic              occupied[SITES];
  aspt_pkg::entry_t  table_q[SITES];
  logic [63:0]       grand_total;

  assign words_pending_o = expected_words.size();

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == COUNT_MAX) ? v : v + 32'd1;
  endfunction

  function automatic void queue_word(profile_word_t w);
    expected_words = {expected_words, w};
  endfunction

  function automatic profile_word_t make_word(logic [1:0] st, logic [31:0] site, int slot);
    profile_word_t w;
    int n;
    w = '0;
    n = 0;
    w.status = st;
    w.site = site;
    if (slot >= 0) begin
      w.allocs = table_q[slot].allocs;
      w.bytes = table_q[slot].bytes;
      w.surv = table_q[slot].surv;
      w.prom = table_q[slot].prom;
      w.tag = table_q[slot].tag;
      w.cls = table_q[slot].cls;
    end
    for (int i = 0; i < SITES; i++) if (occupied[i]) n++;
    w.grand = grand_total;
    w.used = n[6:0];
    return w;
  endfunction

  function automatic int find_site(logic [31:0] site);
    for (int i = 0; i < SITES; i++) if (occupied[i] && table_q[i].site == site) return i;
    return -1;
  endfunction

  task automatic predict_profile(logic [2:0] op, logic [31:0] site, logic [31:0] nbytes,
                                 logic [7:0] tag);
    int slot;
    int n;
    profile_word_t w;
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic ok;
    n = 0;
    case (op) inside
      aspt_pkg::OP_ALLOC: begin
        slot = find_site(site);
        if (slot < 0) begin
          for (int i = 0; i < SITES; i++) if (!occupied[i]) begin
            slot = i;
            break;
          end
          if (slot >= 0) begin
            occupied[slot] = 1'b1;
            table_q[slot] = '0;
            table_q[slot].site = site;
          end
        end
        if (slot < 0) begin
          w = make_word(aspt_pkg::ST_FULL, site, -1);
          full_drops_o++;
        end else begin
          table_q[slot].allocs = sat_inc(table_q[slot].allocs);
          if (BYTES_MAX - table_q[slot].bytes < {16'd0, nbytes}) table_q[slot].bytes = BYTES_MAX;
          else table_q[slot].bytes = table_q[slot].bytes + nbytes;
          table_q[slot].tag = tag;
          table_q[slot].cls = nbytes[aspt_pkg::SIZE_SHIFT +: 16];
          if (GRAND_MAX - grand_total < {32'd0, nbytes}) grand_total = GRAND_MAX;
          else grand_total = grand_total + nbytes;
          w = make_word(aspt_pkg::ST_OK, site, slot);
        end
        w.last = 1'b1;
        queue_word(w);
      end
      aspt_pkg::OP_SURV, aspt_pkg::OP_PROM: begin
        slot = find_site(site);
        if (slot < 0) begin
          w = make_word(aspt_pkg::ST_NOT_FOUND, site, -1);
        end else begin
          if (op == aspt_pkg::OP_SURV) table_q[slot].surv = sat_inc(table_q[slot].surv);
          else table_q[slot].prom = sat_inc(table_q[slot].prom);
          w = make_word(aspt_pkg::ST_OK, site, slot);
        end
        w.last = 1'b1;
        queue_word(w);
      end
      aspt_pkg::OP_DECAY: begin
        for (int i = 0; i < SITES; i++) if (occupied[i]) begin
          table_q[i].allocs = table_q[i].allocs >> 1;
          table_q[i].bytes = table_q[i].bytes >> 1;
          table_q[i].surv = table_q[i].surv >> 1;
          table_q[i].prom = table_q[i].prom >> 1;
        end
        w = make_word(aspt_pkg::ST_OK, 32'd0, -1);
        w.last = 1'b1;
        queue_word(w);
      end
      aspt_pkg::OP_SCAN: begin
        for (int i = 0; i < SITES && n < aspt_pkg::OUT_LIMIT; i++) begin
          if (!occupied[i] || table_q[i].allocs < min_samples) continue;
          lhs = {24'd0, table_q[i].surv, 8'd0};
          rhs = {55'd0, thr_q8} * {32'd0, table_q[i].allocs};
          ok = (table_q[i].allocs == 0) ? (thr_q8 == 0) : (lhs >= rhs);
          if (!ok) continue;
          queue_word(make_word(aspt_pkg::ST_OK, table_q[i].site, i));
          n++;
          scan_words_o++;
        end
        if (n == 0) queue_word(make_word(aspt_pkg::ST_NO_CAND, 32'd0, -1));
        w = expected_words.pop_back();
        w.last = 1'b1;
        queue_word(w);
      end
      default: ;  // Undefined ops are dropped without a word.
    endcase
  endtask

  profile_word_t seen;
  profile_word_t want;
  assign seen = '{status_i, out_site_i, site_allocs_i, site_bytes_i, site_survivals_i,
                  site_promotions_i, last_tag_i, last_class_i, bytes_all_sites_i,
                  sites_in_use_i, last_i};

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q8 <= 9'd128;
      min_samples <= '0;
      grand_total = '0;
      for (int i = 0; i < SITES; i++) occupied[i] = 1'b0;
      fail_count_o = 0;
      words_checked_o = 0;
      full_drops_o = 0;
      scan_words_o = 0;
      expected_words.delete();
    end else begin
      if (result_valid_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, actual %p", $time, seen);
          fail_count_o++;
        end else begin
          want = expected_words.pop_front();
          words_checked_o++;
          if (seen !== want) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, seen);
            fail_count_o++;
          end
        end
      end
      // Prediction runs after the check so a word is never matched to its own item.
      if (start_i && !busy_i) predict_profile(op_i, site_id_i, alloc_bytes_i, type_tag_i);
      if (cfg_we_i) begin
        if (cfg_idx_i == aspt_pkg::REG_THRESHOLD) thr_q8 <= cfg_wdata_i[8:0];
        else min_samples <= cfg_wdata_i;
      end
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the allocation site profile table: clock, reset, stimulus
// and verdict. Depends on aspt_pkg, the block and the aspt_checker module.
`timescale 1ns / 100ps
module tb_top;

  localparam logic [2:0] OP_UNUSED_5 = 3'd5;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;
  localparam int DRAIN_CYCLES = 220;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  op_i = '0;
  logic [31:0] site_id_i = '0;
  logic [31:0] alloc_bytes_i = '0;
  logic [7:0]  type_tag_i = '0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [31:0] out_site_o;
  logic [31:0] site_allocs_o;
  logic [47:0] site_bytes_o;
  logic [31:0] site_survivals_o;
  logic [31:0] site_promotions_o;
  logic [7:0]  last_tag_o;
  logic [15:0] last_class_o;
  logic [63:0] bytes_all_sites_o;
  logic [6:0]  sites_in_use_o;
  logic        last_o;
  int          fail_count, words_pending, words_checked, full_drops, scan_words;
  int          items_sent = 0;
  logic [31:0] site_pool[80];

  always #1 clk_i = ~clk_i;

  allocation_site_profile_table uut (.*);

  aspt_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .op_i, .site_id_i, .alloc_bytes_i,
    .type_tag_i, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .result_valid_i(result_valid_o),
    .status_i(status_o), .out_site_i(out_site_o), .site_allocs_i(site_allocs_o),
    .site_bytes_i(site_bytes_o), .site_survivals_i(site_survivals_o),
    .site_promotions_i(site_promotions_o), .last_tag_i(last_tag_o),
    .last_class_i(last_class_o), .bytes_all_sites_i(bytes_all_sites_o),
    .sites_in_use_i(sites_in_use_o), .last_i(last_o), .fail_count_o(fail_count),
    .words_pending_o(words_pending), .words_checked_o(words_checked),
    .full_drops_o(full_drops), .scan_words_o(scan_words)
  );

  // Holds start high until the block takes the command.
  task automatic issue(logic [2:0] op, logic [31:0] site, logic [31:0] nbytes, logic [7:0] tag);
    start <= 1'b1;
    op_i <= op;
    site_id_i <= site;
    alloc_bytes_i <= nbytes;
    type_tag_i <= tag;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic go_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(logic [8:0] thr, logic [31:0] min_cnt);
    go_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= aspt_pkg::REG_THRESHOLD;
    cfg_wdata_i <= {23'd0, thr};
    @(posedge clk_i);
    cfg_idx_i <= aspt_pkg::REG_MIN_SAMPLES;
    cfg_wdata_i <= min_cnt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random traffic, mostly over the first pool_size sites, mostly allocations and survivals.
  task automatic random_phase(int count, int pool_size);
    int burst;
    int pick;
    logic [2:0] op;
    logic [31:0] nbytes;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && count > 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) op = aspt_pkg::OP_ALLOC;
        else if (pick < 70) op = aspt_pkg::OP_SURV;
        else if (pick < 82) op = aspt_pkg::OP_PROM;
        else if (pick < 87) op = aspt_pkg::OP_DECAY;
        else if (pick < 97) op = aspt_pkg::OP_SCAN;
        else op = 3'($urandom_range(OP_UNUSED_5, OP_UNUSED_7));
        nbytes = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4096);
        issue(op, ($urandom_range(0, 19) == 0) ? $urandom : site_pool[$urandom_range(0, pool_size - 1)],
              nbytes, 8'($urandom));
        if (op < OP_UNUSED_5) count--;
        burst--;
      end
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    foreach (site_pool[i]) site_pool[i] = $urandom;
    site_pool[0] = 32'h0000_0000;
    site_pool[1] = 32'hFFFF_FFFF;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed: empty scan, unknown sites, field extremes, decay, undefined ops.
    issue(aspt_pkg::OP_SCAN, 32'd0, 32'd0, 8'd0);
    issue(aspt_pkg::OP_SURV, 32'hFFFF_FFFF, 32'd0, 8'd0);
    issue(aspt_pkg::OP_PROM, 32'h0000_0000, 32'd0, 8'd0);
    issue(aspt_pkg::OP_DECAY, 32'd0, 32'd0, 8'd0);
    issue(aspt_pkg::OP_ALLOC, 32'h0000_0000, 32'd0, 8'h00);
    issue(aspt_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    issue(aspt_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hA5);
    issue(aspt_pkg::OP_SURV, 32'hFFFF_FFFF, 32'd0, 8'd0);
    issue(aspt_pkg::OP_SURV, 32'hFFFF_FFFF, 32'd0, 8'd0);
    issue(aspt_pkg::OP_PROM, 32'h0000_0000, 32'd0, 8'd0);
    issue(aspt_pkg::OP_SCAN, 32'd0, 32'd0, 8'd0);
    issue(aspt_pkg::OP_DECAY, 32'd0, 32'd0, 8'd0);
    issue(aspt_pkg::OP_SCAN, 32'd0, 32'd0, 8'd0);
    issue(OP_UNUSED_5, 32'd1, 32'd1, 8'd1);
    issue(3'd6, 32'd1, 32'd1, 8'd1);
    issue(OP_UNUSED_7, 32'd1, 32'd1, 8'd1);
    issue(aspt_pkg::OP_ALLOC, 32'h0000_0000, 32'h0007_FFF8, 8'h5A);
    // Zero threshold lets a site with a decayed-to-zero count qualify.
    write_config(9'd0, 32'd0);
    issue(aspt_pkg::OP_DECAY, 32'd0, 32'd0, 8'd0);
    issue(aspt_pkg::OP_DECAY, 32'd0, 32'd0, 8'd0);
    issue(aspt_pkg::OP_SCAN, 32'd0, 32'd0, 8'd0);
    write_config(9'd256, 32'hFFFF_FFFF);
    issue(aspt_pkg::OP_SCAN, 32'd0, 32'd0, 8'd0);

    write_config(9'd128, 32'd0);
    random_phase(30, 6);
    write_config(9'($urandom_range(1, 255)), $urandom_range(1, 4));
    random_phase(25, 10);
    write_config(9'd256, 32'd1);
    random_phase(20, 10);
    // Allocations over the rest of the pool fill every slot, so drops and full scans show up.
    write_config(9'd0, 32'd0);
    for (int i = 10; i < 80; i++) begin
      issue(aspt_pkg::OP_ALLOC, site_pool[i], 32'($urandom_range(0, 4096)), 8'($urandom));
    end
    random_phase(25, 80);
    write_config(9'($urandom_range(0, 256)), 32'd2);
    random_phase(20, 80);

    go_idle();
    $display("tb: %0d commands, %0d words checked, %0d scan hits, %0d dropped allocations",
             items_sent, words_checked, scan_words, full_drops);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
